>>> hdl/ftp_passive_reply_parser_assert.svh
// ----------------------------------------------------------------------------
// ftp_passive_reply_parser_assert: assertion macros
// Clocked assertion shorthands shared by the parser RTL.
// ----------------------------------------------------------------------------
`ifndef FTP_PASSIVE_REPLY_PARSER_ASSERT_SVH
`define FTP_PASSIVE_REPLY_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define FPRP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define FPRP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/fprp_pkg.sv
// ----------------------------------------------------------------------------
// fprp_pkg: FTP passive reply parser package
// Character codes, parser phase codes, field geometry and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fprp_pkg;

  localparam int FIELD_COUNT = 6;
  localparam int IDX_W       = 3;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic PH_WAIT  = 1'b0;
  localparam logic PH_PARSE = 1'b1;

  localparam logic [IDX_W-1:0] IDX_PAST = IDX_W'(FIELD_COUNT);

  typedef struct packed {
    logic [7:0] value;
    logic       ovf;
  } acc_res_t;

endpackage

>>> hdl/ftp_passive_reply_parser.sv
// ----------------------------------------------------------------------------
// ftp_passive_reply_parser: FTP passive-mode reply field parser
// Output path: out_valid rises when the ending byte moves from the input reg
//   into the result reg.
// Throughput: one byte per cycle; an ending byte stalls only while a result
//   waits with out_ready low.
// Reset: rst_n synchronous active low; clears parser state and stage valids.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ftp_passive_reply_parser_assert.svh"

module ftp_passive_reply_parser
  import fprp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // byte input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_last_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_addr_octet_a,
  output logic [7:0]  out_addr_octet_b,
  output logic [7:0]  out_addr_octet_c,
  output logic [7:0]  out_addr_octet_d,
  output logic [7:0]  out_port_high_byte,
  output logic [7:0]  out_port_low_byte,
  output logic [15:0] out_data_port,
  output logic        out_closed,
  output logic        out_overflow
);

  // --------------------------------------------------------------------------
  // Input register: one byte waits here while the parser state is updated.
  // --------------------------------------------------------------------------
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  // parser state
  logic                 phase_r,   phase_nxt;
  logic [IDX_W-1:0]     comma_r,   comma_nxt;
  logic [7:0]           field_r    [FIELD_COUNT];
  logic [7:0]           field_nxt  [FIELD_COUNT];
  logic                 started_r, started_nxt;
  logic                 ended_r,   ended_nxt;
  logic                 ovf_r,     ovf_nxt;

  // result register
  logic       out_valid_r;
  logic [7:0] res_field_r [FIELD_COUNT];
  logic       res_closed_r;
  logic       res_ovf_r;

  logic       emit;
  logic       hit_close;
  logic       out_free;
  logic       s1_go;
  logic [7:0] upd_field [FIELD_COUNT];
  logic       upd_ovf;
  acc_res_t   acc;

  // Emit on ')' while parsing, or on the byte flagged last.
  assign hit_close = (phase_r == PH_PARSE) && (s1_byte_r == CH_RPAREN);
  assign emit      = hit_close || s1_last_r;

  // The result register frees up this cycle if it is empty or being drained.
  assign out_free  = !out_valid_r || out_ready;

  // Advance the held byte unless it must emit into a full result register.
  assign s1_go     = s1_valid_r && (!emit || out_free);
  assign in_ready  = !s1_valid_r || s1_go;

  // Digit accumulate for the current field; the index is guarded below.
  fprp_digit_acc u_acc (
    .cur_value (field_r[comma_r]),
    .digit     (s1_byte_r[3:0]),
    .res       (acc)
  );

  // --------------------------------------------------------------------------
  // Next-state logic for one byte.
  // --------------------------------------------------------------------------
  always_comb begin
    phase_nxt   = phase_r;
    comma_nxt   = comma_r;
    started_nxt = started_r;
    ended_nxt   = ended_r;
    upd_ovf     = ovf_r;
    for (int k = 0; k < FIELD_COUNT; k++) begin
      upd_field[k] = field_r[k];
    end

    if (phase_r == PH_WAIT) begin
      if (s1_byte_r == CH_LPAREN) begin
        phase_nxt = PH_PARSE;
      end
    end else if (!hit_close) begin
      if (s1_byte_r == CH_COMMA) begin
        // step to the next field; the ignored slot past the sixth is sticky
        if (comma_r < IDX_PAST) begin
          comma_nxt = comma_r + 1'b1;
        end
        started_nxt = 1'b0;
        ended_nxt   = 1'b0;
      end else if ((comma_r < IDX_PAST) && !ended_r) begin
        if ((s1_byte_r == CH_SPACE) && !started_r) begin
          // skip leading spaces
        end else if (s1_byte_r inside {[CH_ZERO:CH_NINE]}) begin
          upd_field[comma_r] = acc.value;
          upd_ovf            = ovf_r | acc.ovf;
          started_nxt        = 1'b1;
        end else begin
          // any other character stops the digits of this field
          ended_nxt = 1'b1;
        end
      end
    end

    // An emitting byte returns the parser to its reset state.
    if (emit) begin
      phase_nxt   = PH_WAIT;
      comma_nxt   = '0;
      started_nxt = 1'b0;
      ended_nxt   = 1'b0;
      ovf_nxt     = 1'b0;
      for (int k = 0; k < FIELD_COUNT; k++) begin
        field_nxt[k] = 8'h00;
      end
    end else begin
      ovf_nxt = upd_ovf;
      for (int k = 0; k < FIELD_COUNT; k++) begin
        field_nxt[k] = upd_field[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  // payload of the input register: load on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_rx_byte;
      s1_last_r <= in_last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_WAIT;
      comma_r   <= '0;
      started_r <= 1'b0;
      ended_r   <= 1'b0;
      ovf_r     <= 1'b0;
      for (int k = 0; k < FIELD_COUNT; k++) begin
        field_r[k] <= 8'h00;
      end
    end else if (s1_go) begin
      phase_r   <= phase_nxt;
      comma_r   <= comma_nxt;
      started_r <= started_nxt;
      ended_r   <= ended_nxt;
      ovf_r     <= ovf_nxt;
      for (int k = 0; k < FIELD_COUNT; k++) begin
        field_r[k] <= field_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload: fields as they stand after this byte, before the clear
  always_ff @(posedge clk) begin
    if (s1_go && emit) begin
      for (int k = 0; k < FIELD_COUNT; k++) begin
        res_field_r[k] <= upd_field[k];
      end
      res_closed_r <= hit_close;
      res_ovf_r    <= upd_ovf;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_addr_octet_a   = res_field_r[0];
  assign out_addr_octet_b   = res_field_r[1];
  assign out_addr_octet_c   = res_field_r[2];
  assign out_addr_octet_d   = res_field_r[3];
  assign out_port_high_byte = res_field_r[4];
  assign out_port_low_byte  = res_field_r[5];
  assign out_data_port      = {res_field_r[4], res_field_r[5]};
  assign out_closed         = res_closed_r;
  assign out_overflow       = res_ovf_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `FPRP_ASSERT_NEXT(a_emit_loads, s1_go && emit, out_valid_r, "emit did not load result")
  `FPRP_ASSERT_NEXT(a_emit_clears, s1_go && emit,
    (phase_r == PH_WAIT) && (comma_r == '0), "state not cleared after emit")
  `FPRP_ASSERT_NOW(a_wait_clean, phase_r == PH_WAIT,
    (comma_r == '0) && !ovf_r && !started_r, "dirty state while waiting")
  `FPRP_ASSERT_NEXT(a_hold_byte, s1_valid_r && !s1_go,
    s1_valid_r && $stable(s1_byte_r), "stalled byte lost")
  `FPRP_ASSERT_NOW(a_index_range, s1_valid_r, comma_r <= IDX_PAST, "field index out of range")

endmodule

>>> hdl/fprp_digit_acc.sv
// ----------------------------------------------------------------------------
// fprp_digit_acc: decimal digit accumulator
// Computes value * 10 + digit, saturated at 255 with an overflow flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fprp_digit_acc
  import fprp_pkg::*;
(
  input  logic [7:0] cur_value,
  input  logic [3:0] digit,
  output acc_res_t   res
);

  logic [11:0] sum;

  // times ten as shift-and-add
  assign sum = {1'b0, cur_value, 3'b000} + {3'b000, cur_value, 1'b0} + {8'h00, digit};

  always_comb begin
    if (sum > 12'd255) begin
      res.value = 8'hFF;
      res.ovf   = 1'b1;
    end else begin
      res.value = sum[7:0];
      res.ovf   = 1'b0;
    end
  end

endmodule
